### src/cycle_timing_stats_monitor_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the cycle timing statistics monitor
// Immediate-style wrappers around concurrent assertions; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef CYCLE_TIMING_STATS_MONITOR_DEFINES_SVH
`define CYCLE_TIMING_STATS_MONITOR_DEFINES_SVH

`ifndef SYNTHESIS

// A property that must hold at every clock edge out of reset.
`define CTSM_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// A condition that must be followed by another one in the next cycle.
`define CTSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`else

`define CTSM_ASSERT(label, clk, rst_n, prop, msg)
`define CTSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)

`endif

`endif

### src/ctsm_pkg.sv
// ----------------------------------------------------------------------------
// ctsm_pkg
// Types, register map and constants shared by the timing statistics monitor.
// ----------------------------------------------------------------------------
package ctsm_pkg;

    localparam int BUCKETS_DEF = 4;

    // Configuration port geometry: seven registers at 8-byte strides.
    localparam int ADDR_W = 6;
    localparam int DATA_W = 64;

    localparam logic [2:0] REG_PERIOD = 3'd0;
    localparam logic [2:0] REG_HZ     = 3'd1;
    localparam logic [2:0] REG_WARMUP = 3'd2;
    localparam logic [2:0] REG_FDL    = 3'd3;
    localparam logic [2:0] REG_BLIM0  = 3'd4;
    localparam logic [2:0] REG_BLIM1  = 3'd5;
    localparam logic [2:0] REG_BLIM2  = 3'd6;

    localparam logic [31:0] PERIOD_RST = 32'd1000;
    localparam logic [31:0] HZ_RST     = 32'd0;
    localparam logic [31:0] WARMUP_RST = 32'd1000;
    localparam logic [63:0] FDL_RST    = 64'd0;
    localparam logic [31:0] BLIM0_RST  = 32'd10;
    localparam logic [31:0] BLIM1_RST  = 32'd50;
    localparam logic [31:0] BLIM2_RST  = 32'd100;

    // Microseconds per second, and the width of a 32 bit half times it.
    localparam logic [19:0] US_PER_S  = 20'd1000000;
    localparam int          MUL_W     = 52;
    localparam int          DIV_STEPS = 32;

    localparam logic [2:0] NO_BUCKET = 3'd4;

    localparam int IN_W  = 176;
    localparam int OUT_W = 456;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_LIMIT,
        ST_OVER,
        ST_OFF,
        ST_DL,
        ST_CYC,
        ST_PALL,
        ST_WARM,
        ST_PMIN,
        ST_PMAX,
        ST_PSUM,
        ST_WMAX,
        ST_WSUM,
        ST_MUL_LO,
        ST_MUL_HI,
        ST_MUL_ADD,
        ST_SAT,
        ST_DIV,
        ST_BKT,
        ST_HIST,
        ST_FINISH
    } state_t;

    typedef enum logic {
        ALU_ADD,
        ALU_SUB
    } alu_op_t;

    // carry is the carry out of an add or the borrow out of a subtract.
    typedef struct packed {
        logic        carry;
        logic [63:0] value;
    } alu_res_t;

    // Input item, last field in the lowest bits.
    typedef struct packed {
        logic [15:0] work_counter;
        logic [31:0] proc_cycles;
        logic [63:0] wake_tick;
        logic [63:0] start_tick;
    } in_t;

    // Result item, last field in the lowest bits, zero padded to bytes.
    typedef struct packed {
        logic [4:0]  pad;
        logic [63:0] wake_total;
        logic [63:0] wake_peak;
        logic [63:0] proc_total;
        logic [31:0] proc_peak;
        logic [31:0] proc_least;
        logic [31:0] sample_count;
        logic [31:0] proc_peak_all;
        logic [31:0] ok_count;
        logic [31:0] overrun_count;
        logic [31:0] cycle_count;
        logic [31:0] bucket_count;
        logic [2:0]  bucket;
    } out_t;

endpackage

### src/ctsm_alu.sv
// ----------------------------------------------------------------------------
// ctsm_alu
// Shared 64-bit adder and subtractor with carry or borrow out.
// ----------------------------------------------------------------------------
module ctsm_alu
    import ctsm_pkg::*;
(
    input  alu_op_t     op,
    input  logic [63:0] a,
    input  logic [63:0] b,
    output alu_res_t    res
);

    logic [64:0] sum;

    always_comb
    begin
        case (op)
            ALU_ADD: sum = {1'b0, a} + {1'b0, b};
            ALU_SUB: sum = {1'b0, a} - {1'b0, b};
            default: sum = '0;
        endcase
        res.carry = sum[64];
        res.value = sum[63:0];
    end

endmodule

### src/cycle_timing_stats_monitor.sv
// ----------------------------------------------------------------------------
// cycle_timing_stats_monitor
// Collects timing statistics of a periodic control loop, one item per loop.
// Items enter on the s_ stream: start tick, wake tick, processing cycles and
// working counter. Each item gives exactly one result on the m_ stream with
// the histogram bucket hit and a snapshot of all counters, peaks and sums.
// Registers must be written over the APB port only while the block is idle;
// the block itself does not enforce this. Writing first_deadline also
// reloads the running deadline. One 64-bit adder is shared by the add,
// subtract and compare steps under a sequencer. Past warm-up, a nonzero
// timer_hz brings in the microsecond conversion, where 32 restoring divide
// steps run through that adder unless the value saturates. The bucket scan
// tests the limits one by one. The block takes the next item only once the
// sequencer is back in idle, and s_tready is high only while it is idle.
// A result waits in the output register until taken; a new item is
// accepted meanwhile, and the sequencer holds the next result until the
// register is free. Reset clears all statistics and returns the registers
// to their defaults.
// ----------------------------------------------------------------------------
`include "cycle_timing_stats_monitor_defines.svh"

module cycle_timing_stats_monitor
    import ctsm_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    // start_tick[63:0], wake_tick[127:64], proc_cycles[159:128],
    // work_counter[175:160]
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,

    // bucket[2:0], bucket_count[34:3], cycle_count[66:35],
    // overrun_count[98:67], ok_count[130:99], proc_peak_all[162:131],
    // sample_count[194:163], proc_least[226:195], proc_peak[258:227],
    // proc_total[322:259], wake_peak[386:323], wake_total[450:387], zeros above
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [OUT_W-1:0]  m_tdata,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    output logic [DATA_W-1:0] prdata,
    output logic              pready
);

    localparam int IDX_W = $clog2(BUCKETS);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(BUCKETS - 1);
    localparam logic [IDX_W-1:0] SCAN_END = IDX_W'(BUCKETS - 2);

    // Sequencer and handshake state.
    state_t state_reg, state_next;
    logic   m_valid_reg, m_valid_next;
    out_t   out_reg, out_next;

    // Configuration registers.
    logic [31:0] period_reg, period_next;
    logic [31:0] hz_reg, hz_next;
    logic [31:0] warmup_reg, warmup_next;
    logic [63:0] first_dl_reg, first_dl_next;
    logic [31:0] blim0_reg, blim0_next;
    logic [31:0] blim1_reg, blim1_next;
    logic [31:0] blim2_reg, blim2_next;

    // Running statistics.
    logic [63:0] deadline_reg, deadline_next;
    logic [63:0] cycles_reg, cycles_next;
    logic [31:0] overruns_reg, overruns_next;
    logic [31:0] ok_reg, ok_next;
    logic [31:0] peak_all_reg, peak_all_next;
    logic [31:0] samples_reg, samples_next;
    logic [31:0] least_reg, least_next;
    logic [31:0] peak_proc_reg, peak_proc_next;
    logic [63:0] sum_proc_reg, sum_proc_next;
    logic [63:0] peak_wake_reg, peak_wake_next;
    logic [63:0] sum_wake_reg, sum_wake_next;
    logic        have_sample_reg, have_sample_next;
    logic [31:0] hist_reg [BUCKETS];
    logic [31:0] hist_next [BUCKETS];

    // Working registers of the item in flight.
    logic [63:0]      start_reg, start_next;
    logic [63:0]      wake_reg, wake_next;
    logic [31:0]      proc_reg, proc_next;
    logic             wkc_nz_reg, wkc_nz_next;
    logic [63:0]      limit_reg, limit_next;
    logic             carry_reg, carry_next;
    logic             over_reg, over_next;
    logic [63:0]      off_reg, off_next;
    logic [MUL_W-1:0] mul_reg, mul_next;
    logic [MUL_W-1:0] prod_hi_reg, prod_hi_next;
    logic [31:0]      prod_lo_reg, prod_lo_next;
    logic [31:0]      rem_reg, rem_next;
    logic [31:0]      quo_reg, quo_next;
    logic [31:0]      us_reg, us_next;
    logic [4:0]       cnt_reg, cnt_next;
    logic [IDX_W-1:0] bkt_idx_reg, bkt_idx_next;
    logic [IDX_W-1:0] hit_idx_reg, hit_idx_next;
    logic [2:0]       bucket_reg, bucket_next;
    logic [31:0]      bcount_reg, bcount_next;

    // Shared arithmetic.
    alu_op_t          alu_op;
    logic [63:0]      alu_a;
    logic [63:0]      alu_b;
    alu_res_t         alu_res;
    logic [31:0]      mul_in;
    logic [MUL_W-1:0] mul_out;
    logic [32:0]      div_shift;
    logic [31:0]      blim_sel;

    in_t         in_item;
    logic        cfg_we;
    logic [2:0]  cfg_idx;

    ctsm_alu u_alu
    (
        .op  (alu_op),
        .a   (alu_a),
        .b   (alu_b),
        .res (alu_res)
    );

    assign in_item  = s_tdata;
    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = out_reg;
    assign pready   = 1'b1;
    assign cfg_we   = psel & penable & pwrite & pready;
    assign cfg_idx  = paddr[ADDR_W-1:3];

    // One 32 by 20 bit multiplier serves both halves of the offset.
    assign mul_in    = (state_reg == ST_MUL_LO) ? off_reg[31:0] : off_reg[63:32];
    assign mul_out   = MUL_W'(mul_in) * MUL_W'(US_PER_S);
    assign div_shift = {rem_reg, prod_lo_reg[31]};

    always_comb
    begin
        case (2'(bkt_idx_reg))
            2'd0:    blim_sel = blim0_reg;
            2'd1:    blim_sel = blim1_reg;
            default: blim_sel = blim2_reg;
        endcase
    end

    always_comb
    begin
        case (cfg_idx)
            REG_PERIOD: prdata = 64'(period_reg);
            REG_HZ:     prdata = 64'(hz_reg);
            REG_WARMUP: prdata = 64'(warmup_reg);
            REG_FDL:    prdata = first_dl_reg;
            REG_BLIM0:  prdata = 64'(blim0_reg);
            REG_BLIM1:  prdata = 64'(blim1_reg);
            REG_BLIM2:  prdata = 64'(blim2_reg);
            default:    prdata = '0;
        endcase
    end

    always_comb
    begin
        state_next       = state_reg;
        m_valid_next     = m_valid_reg;
        out_next         = out_reg;
        period_next      = period_reg;
        hz_next          = hz_reg;
        warmup_next      = warmup_reg;
        first_dl_next    = first_dl_reg;
        blim0_next       = blim0_reg;
        blim1_next       = blim1_reg;
        blim2_next       = blim2_reg;
        deadline_next    = deadline_reg;
        cycles_next      = cycles_reg;
        overruns_next    = overruns_reg;
        ok_next          = ok_reg;
        peak_all_next    = peak_all_reg;
        samples_next     = samples_reg;
        least_next       = least_reg;
        peak_proc_next   = peak_proc_reg;
        sum_proc_next    = sum_proc_reg;
        peak_wake_next   = peak_wake_reg;
        sum_wake_next    = sum_wake_reg;
        have_sample_next = have_sample_reg;
        hist_next        = hist_reg;
        start_next       = start_reg;
        wake_next        = wake_reg;
        proc_next        = proc_reg;
        wkc_nz_next      = wkc_nz_reg;
        limit_next       = limit_reg;
        carry_next       = carry_reg;
        over_next        = over_reg;
        off_next         = off_reg;
        mul_next         = mul_reg;
        prod_hi_next     = prod_hi_reg;
        prod_lo_next     = prod_lo_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        us_next          = us_reg;
        cnt_next         = cnt_reg;
        bkt_idx_next     = bkt_idx_reg;
        hit_idx_next     = hit_idx_reg;
        bucket_next      = bucket_reg;
        bcount_next      = bcount_reg;
        alu_op           = ALU_ADD;
        alu_a            = '0;
        alu_b            = '0;

        if (m_valid_reg && m_tready)
        begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (s_tvalid)
                begin
                    start_next  = in_item.start_tick;
                    wake_next   = in_item.wake_tick;
                    proc_next   = in_item.proc_cycles;
                    wkc_nz_next = (in_item.work_counter != 16'd0);
                    state_next  = ST_LIMIT;
                end
            end

            // Limit of the current period; a carry means no start can reach it.
            ST_LIMIT:
            begin
                alu_op     = ALU_ADD;
                alu_a      = deadline_reg;
                alu_b      = 64'(period_reg);
                limit_next = alu_res.value;
                carry_next = alu_res.carry;
                state_next = ST_OVER;
            end

            ST_OVER:
            begin
                alu_op     = ALU_SUB;
                alu_a      = start_reg;
                alu_b      = limit_reg;
                over_next  = !carry_reg && !alu_res.carry;
                state_next = ST_OFF;
            end

            // On an overrun the start is never below the deadline, so one
            // subtract with a zero floor covers both kinds of offset.
            ST_OFF:
            begin
                alu_op     = ALU_SUB;
                alu_a      = over_reg ? start_reg : wake_reg;
                alu_b      = deadline_reg;
                off_next   = alu_res.carry ? 64'd0 : alu_res.value;
                state_next = ST_DL;
            end

            ST_DL:
            begin
                alu_op        = ALU_ADD;
                alu_a         = start_reg;
                alu_b         = 64'(period_reg);
                deadline_next = over_reg ? alu_res.value : limit_reg;
                if (over_reg)
                begin
                    overruns_next = overruns_reg + 32'd1;
                end
                if (wkc_nz_reg)
                begin
                    ok_next = ok_reg + 32'd1;
                end
                state_next = ST_CYC;
            end

            ST_CYC:
            begin
                alu_op      = ALU_ADD;
                alu_a       = cycles_reg;
                alu_b       = 64'd1;
                cycles_next = alu_res.value;
                state_next  = ST_PALL;
            end

            ST_PALL:
            begin
                alu_op = ALU_SUB;
                alu_a  = 64'(peak_all_reg);
                alu_b  = 64'(proc_reg);
                if (alu_res.carry)
                begin
                    peak_all_next = proc_reg;
                end
                state_next = ST_WARM;
            end

            // A borrow from warmup minus cycles means warm-up is over.
            ST_WARM:
            begin
                alu_op = ALU_SUB;
                alu_a  = 64'(warmup_reg);
                alu_b  = cycles_reg;
                if (alu_res.carry)
                begin
                    samples_next     = samples_reg + 32'd1;
                    have_sample_next = 1'b1;
                    state_next       = ST_PMIN;
                end
                else
                begin
                    bucket_next = NO_BUCKET;
                    bcount_next = 32'd0;
                    state_next  = ST_FINISH;
                end
            end

            ST_PMIN:
            begin
                alu_op = ALU_SUB;
                alu_a  = 64'(proc_reg);
                alu_b  = 64'(least_reg);
                if (alu_res.carry)
                begin
                    least_next = proc_reg;
                end
                state_next = ST_PMAX;
            end

            ST_PMAX:
            begin
                alu_op = ALU_SUB;
                alu_a  = 64'(peak_proc_reg);
                alu_b  = 64'(proc_reg);
                if (alu_res.carry)
                begin
                    peak_proc_next = proc_reg;
                end
                state_next = ST_PSUM;
            end

            ST_PSUM:
            begin
                alu_op        = ALU_ADD;
                alu_a         = sum_proc_reg;
                alu_b         = 64'(proc_reg);
                sum_proc_next = alu_res.value;
                state_next    = ST_WMAX;
            end

            ST_WMAX:
            begin
                alu_op = ALU_SUB;
                alu_a  = peak_wake_reg;
                alu_b  = off_reg;
                if (alu_res.carry)
                begin
                    peak_wake_next = off_reg;
                end
                state_next = ST_WSUM;
            end

            ST_WSUM:
            begin
                alu_op        = ALU_ADD;
                alu_a         = sum_wake_reg;
                alu_b         = off_reg;
                sum_wake_next = alu_res.value;
                if (hz_reg == 32'd0)
                begin
                    us_next      = 32'd0;
                    bkt_idx_next = '0;
                    state_next   = ST_BKT;
                end
                else
                begin
                    state_next = ST_MUL_LO;
                end
            end

            // Low half product: its low word is final, its top bits carry up.
            ST_MUL_LO:
            begin
                prod_lo_next = mul_out[31:0];
                prod_hi_next = MUL_W'(mul_out[MUL_W-1:32]);
                state_next   = ST_MUL_HI;
            end

            ST_MUL_HI:
            begin
                mul_next   = mul_out;
                state_next = ST_MUL_ADD;
            end

            ST_MUL_ADD:
            begin
                alu_op       = ALU_ADD;
                alu_a        = 64'(mul_reg);
                alu_b        = 64'(prod_hi_reg);
                prod_hi_next = alu_res.value[MUL_W-1:0];
                state_next   = ST_SAT;
            end

            // The quotient needs more than 32 bits exactly when the product
            // from bit 32 up reaches the frequency; otherwise that upper part
            // is already the remainder that the last 32 steps start from.
            ST_SAT:
            begin
                alu_op = ALU_SUB;
                alu_a  = 64'(prod_hi_reg);
                alu_b  = 64'(hz_reg);
                if (!alu_res.carry)
                begin
                    us_next      = '1;
                    bkt_idx_next = '0;
                    state_next   = ST_BKT;
                end
                else
                begin
                    rem_next   = prod_hi_reg[31:0];
                    quo_next   = 32'd0;
                    cnt_next   = 5'd0;
                    state_next = ST_DIV;
                end
            end

            // One restoring divide step per cycle on the shared subtractor.
            ST_DIV:
            begin
                alu_op       = ALU_SUB;
                alu_a        = 64'(div_shift);
                alu_b        = 64'(hz_reg);
                rem_next     = alu_res.carry ? div_shift[31:0] : alu_res.value[31:0];
                quo_next     = {quo_reg[30:0], !alu_res.carry};
                prod_lo_next = {prod_lo_reg[30:0], 1'b0};
                cnt_next     = cnt_reg + 5'd1;
                if (cnt_reg == 5'(DIV_STEPS - 1))
                begin
                    us_next      = {quo_reg[30:0], !alu_res.carry};
                    bkt_idx_next = '0;
                    state_next   = ST_BKT;
                end
            end

            // Scan the limits in order; the last bucket takes what is left.
            ST_BKT:
            begin
                alu_op = ALU_SUB;
                alu_a  = 64'(us_reg);
                alu_b  = 64'(blim_sel);
                if (alu_res.carry)
                begin
                    hit_idx_next = bkt_idx_reg;
                    bucket_next  = 3'(bkt_idx_reg);
                    state_next   = ST_HIST;
                end
                else if (bkt_idx_reg == SCAN_END)
                begin
                    hit_idx_next = LAST_IDX;
                    bucket_next  = 3'(LAST_IDX);
                    state_next   = ST_HIST;
                end
                else
                begin
                    bkt_idx_next = bkt_idx_reg + IDX_W'(1);
                end
            end

            ST_HIST:
            begin
                alu_op                 = ALU_ADD;
                alu_a                  = 64'(hist_reg[hit_idx_reg]);
                alu_b                  = 64'd1;
                hist_next[hit_idx_reg] = alu_res.value[31:0];
                bcount_next            = alu_res.value[31:0];
                state_next             = ST_FINISH;
            end

            ST_FINISH:
            begin
                if (!m_valid_reg || m_tready)
                begin
                    out_next.pad           = '0;
                    out_next.wake_total    = sum_wake_reg;
                    out_next.wake_peak     = peak_wake_reg;
                    out_next.proc_total    = sum_proc_reg;
                    out_next.proc_peak     = peak_proc_reg;
                    out_next.proc_least    = have_sample_reg ? least_reg : 32'd0;
                    out_next.sample_count  = samples_reg;
                    out_next.proc_peak_all = peak_all_reg;
                    out_next.ok_count      = ok_reg;
                    out_next.overrun_count = overruns_reg;
                    out_next.cycle_count   = cycles_reg[31:0];
                    out_next.bucket_count  = bcount_reg;
                    out_next.bucket        = bucket_reg;
                    m_valid_next           = 1'b1;
                    state_next             = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (cfg_we)
        begin
            case (cfg_idx)
                REG_PERIOD: period_next = pwdata[31:0];
                REG_HZ:     hz_next     = pwdata[31:0];
                REG_WARMUP: warmup_next = pwdata[31:0];
                REG_FDL:
                begin
                    first_dl_next = pwdata;
                    deadline_next = pwdata;
                end
                REG_BLIM0:  blim0_next  = pwdata[31:0];
                REG_BLIM1:  blim1_next  = pwdata[31:0];
                REG_BLIM2:  blim2_next  = pwdata[31:0];
                default:    ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            m_valid_reg     <= 1'b0;
            period_reg      <= PERIOD_RST;
            hz_reg          <= HZ_RST;
            warmup_reg      <= WARMUP_RST;
            first_dl_reg    <= FDL_RST;
            blim0_reg       <= BLIM0_RST;
            blim1_reg       <= BLIM1_RST;
            blim2_reg       <= BLIM2_RST;
            deadline_reg    <= FDL_RST;
            cycles_reg      <= '0;
            overruns_reg    <= '0;
            ok_reg          <= '0;
            peak_all_reg    <= '0;
            samples_reg     <= '0;
            least_reg       <= '1;
            peak_proc_reg   <= '0;
            sum_proc_reg    <= '0;
            peak_wake_reg   <= '0;
            sum_wake_reg    <= '0;
            have_sample_reg <= 1'b0;
            cnt_reg         <= '0;
            bkt_idx_reg     <= '0;
            for (int i = 0; i < BUCKETS; i++)
            begin
                hist_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg       <= state_next;
            m_valid_reg     <= m_valid_next;
            period_reg      <= period_next;
            hz_reg          <= hz_next;
            warmup_reg      <= warmup_next;
            first_dl_reg    <= first_dl_next;
            blim0_reg       <= blim0_next;
            blim1_reg       <= blim1_next;
            blim2_reg       <= blim2_next;
            deadline_reg    <= deadline_next;
            cycles_reg      <= cycles_next;
            overruns_reg    <= overruns_next;
            ok_reg          <= ok_next;
            peak_all_reg    <= peak_all_next;
            samples_reg     <= samples_next;
            least_reg       <= least_next;
            peak_proc_reg   <= peak_proc_next;
            sum_proc_reg    <= sum_proc_next;
            peak_wake_reg   <= peak_wake_next;
            sum_wake_reg    <= sum_wake_next;
            have_sample_reg <= have_sample_next;
            cnt_reg         <= cnt_next;
            bkt_idx_reg     <= bkt_idx_next;
            hist_reg        <= hist_next;
        end
    end

    // Item payload and intermediate values carry no reset.
    always_ff @(posedge clk)
    begin
        out_reg     <= out_next;
        start_reg   <= start_next;
        wake_reg    <= wake_next;
        proc_reg    <= proc_next;
        wkc_nz_reg  <= wkc_nz_next;
        limit_reg   <= limit_next;
        carry_reg   <= carry_next;
        over_reg    <= over_next;
        off_reg     <= off_next;
        mul_reg     <= mul_next;
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        rem_reg     <= rem_next;
        quo_reg     <= quo_next;
        us_reg      <= us_next;
        hit_idx_reg <= hit_idx_next;
        bucket_reg  <= bucket_next;
        bcount_reg  <= bcount_next;
    end

    `CTSM_ASSERT_NEXT(a_accept_starts, clk, rst_n, s_tvalid && s_tready, state_reg == ST_LIMIT, "accepted item did not start the sequencer")

    `CTSM_ASSERT(a_rem_below_hz, clk, rst_n, (state_reg == ST_DIV) |-> (rem_reg < hz_reg), "divider remainder reached the frequency")

    `CTSM_ASSERT(a_bucket_range, clk, rst_n, m_valid_reg |-> ((out_reg.bucket == NO_BUCKET) || (out_reg.bucket < 3'(BUCKETS))), "result bucket out of range")

    `CTSM_ASSERT(a_proc_order, clk, rst_n, (m_valid_reg && (out_reg.sample_count != 32'd0)) |-> ((out_reg.proc_least <= out_reg.proc_peak) && (out_reg.proc_peak <= out_reg.proc_peak_all)), "processing minimum and peaks out of order")

endmodule

### test/cycle_stats_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Cycle statistics checker
// Watches the register port and both item streams of the timing monitor. It
// keeps its own copy of the registers and of the running statistics, works
// out the result that every accepted item must give, and compares each
// result that leaves the block, field by field, with the oldest one due.
// ----------------------------------------------------------------------------
module cycle_stats_checker
    import ctsm_pkg::*;
#(
    parameter int BUCKETS = BUCKETS_DEF
)
(
    input  logic              clk,
    input  logic              rst_n,

    input  logic              s_tvalid,
    input  logic              s_tready,
    input  logic [IN_W-1:0]   s_tdata,

    input  logic              m_tvalid,
    input  logic              m_tready,
    input  logic [OUT_W-1:0]  m_tdata,

    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [DATA_W-1:0] pwdata,
    input  logic              pready,

    output int                mismatches,
    output int                outstanding,
    output int                compared,
    output int                overruns,
    output int                sampled
);

    // Register copies.
    logic [31:0] period_q;
    logic [31:0] hz_q;
    logic [31:0] warmup_q;
    logic [31:0] lim_q [3];

    // Running statistics.
    logic [63:0] dl;
    logic [63:0] cyc_total;
    logic [31:0] over_n;
    logic [31:0] ok_n;
    logic [31:0] peak_all_q;
    logic [31:0] samp_n;
    logic [31:0] least_q;
    logic [31:0] peak_q;
    logic [63:0] proc_acc;
    logic [63:0] wake_top;
    logic [63:0] wake_acc;
    logic [31:0] hist [BUCKETS];
    bit          got_sample;

    out_t        stats_due [$];
    out_t        next_due;
    int          mismatch_n = 0;
    int          compared_n = 0;

    task automatic load_defaults();
        period_q   = PERIOD_RST;
        hz_q       = HZ_RST;
        warmup_q   = WARMUP_RST;
        lim_q[0]   = BLIM0_RST;
        lim_q[1]   = BLIM1_RST;
        lim_q[2]   = BLIM2_RST;
        dl         = FDL_RST;
        cyc_total  = '0;
        over_n     = '0;
        ok_n       = '0;
        peak_all_q = '0;
        samp_n     = '0;
        least_q    = '1;
        peak_q     = '0;
        proc_acc   = '0;
        wake_top   = '0;
        wake_acc   = '0;
        got_sample = 1'b0;
        for (int i = 0; i < BUCKETS; i++)
            hist[i] = '0;
        stats_due.delete();
    endtask

    task automatic apply_write(input logic [2:0] idx, input logic [DATA_W-1:0] value);
        case (idx)
            REG_PERIOD: period_q = value[31:0];
            REG_HZ:     hz_q     = value[31:0];
            REG_WARMUP: warmup_q = value[31:0];
            REG_FDL:    dl       = value;
            REG_BLIM0:  lim_q[0] = value[31:0];
            REG_BLIM1:  lim_q[1] = value[31:0];
            REG_BLIM2:  lim_q[2] = value[31:0];
            default:    ;
        endcase
    endtask

    // Exact offset * 1e6 / hz, clipped to 32 bits; hz must not be zero.
    function automatic logic [31:0] ticks_to_us(input logic [63:0] off,
                                                input logic [31:0] hz);
        logic [127:0] scaled;
        logic [127:0] quo;
        scaled = {64'd0, off} * {108'd0, US_PER_S};
        quo    = scaled / {96'd0, hz};
        return (quo > 128'hFFFF_FFFF) ? 32'hFFFF_FFFF : quo[31:0];
    endfunction

    task automatic advance_cycle_stats(input in_t it, output out_t res);
        logic [64:0] reach;
        logic [63:0] off;
        logic [31:0] us;
        int          slot;

        // The 65th bit flags a deadline that no start tick can reach.
        reach = {1'b0, dl} + {33'd0, period_q};
        if (!reach[64] && it.start_tick >= reach[63:0]) begin
            over_n++;
            off = it.start_tick - dl;
            dl  = it.start_tick + {32'd0, period_q};
        end
        else begin
            off = (it.wake_tick > dl) ? it.wake_tick - dl : 64'd0;
            dl  = reach[63:0];
        end

        if (it.proc_cycles > peak_all_q)
            peak_all_q = it.proc_cycles;
        if (it.work_counter != 16'd0)
            ok_n++;
        cyc_total++;

        res        = '0;
        res.bucket = NO_BUCKET;
        if (cyc_total > {32'd0, warmup_q}) begin
            us = (hz_q != 32'd0) ? ticks_to_us(off, hz_q) : 32'd0;
            samp_n++;
            if (it.proc_cycles < least_q)
                least_q = it.proc_cycles;
            if (it.proc_cycles > peak_q)
                peak_q = it.proc_cycles;
            got_sample = 1'b1;
            proc_acc += {32'd0, it.proc_cycles};
            if (off > wake_top)
                wake_top = off;
            wake_acc += off;
            // First bucket whose bound lies above the value, else the last one.
            slot = 0;
            while (slot < BUCKETS - 1 && us >= lim_q[slot])
                slot++;
            hist[slot]++;
            res.bucket       = 3'(slot);
            res.bucket_count = hist[slot];
        end

        res.cycle_count   = cyc_total[31:0];
        res.overrun_count = over_n;
        res.ok_count      = ok_n;
        res.proc_peak_all = peak_all_q;
        res.sample_count  = samp_n;
        res.proc_least    = got_sample ? least_q : 32'd0;
        res.proc_peak     = peak_q;
        res.proc_total    = proc_acc;
        res.wake_peak     = wake_top;
        res.wake_total    = wake_acc;
    endtask

    task automatic check_field(input string label, input logic [63:0] want,
                               input logic [63:0] got);
        if (want !== got) begin
            if (mismatch_n < 10)
                $display("%0t ns: result %0d, %s expected %h, got %h",
                         $time, compared_n, label, want, got);
            mismatch_n++;
        end
    endtask

    task automatic check_result(input out_t got);
        out_t want;
        if (stats_due.size() == 0) begin
            if (mismatch_n < 10)
                $display("%0t ns: result arrived with no item outstanding", $time);
            mismatch_n++;
        end
        else begin
            want = stats_due.pop_front();
            check_field("bucket",        64'(want.bucket),        64'(got.bucket));
            check_field("bucket_count",  64'(want.bucket_count),  64'(got.bucket_count));
            check_field("cycle_count",   64'(want.cycle_count),   64'(got.cycle_count));
            check_field("overrun_count", 64'(want.overrun_count), 64'(got.overrun_count));
            check_field("ok_count",      64'(want.ok_count),      64'(got.ok_count));
            check_field("proc_peak_all", 64'(want.proc_peak_all), 64'(got.proc_peak_all));
            check_field("sample_count",  64'(want.sample_count),  64'(got.sample_count));
            check_field("proc_least",    64'(want.proc_least),    64'(got.proc_least));
            check_field("proc_peak",     64'(want.proc_peak),     64'(got.proc_peak));
            check_field("proc_total",    want.proc_total,         got.proc_total);
            check_field("wake_peak",     want.wake_peak,          got.wake_peak);
            check_field("wake_total",    want.wake_total,         got.wake_total);
            check_field("padding",       64'(want.pad),           64'(got.pad));
            compared_n++;
        end
    endtask

    // Results are compared before a new item is booked, so an item taken at
    // the same edge as a result can never be matched against it.
    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            load_defaults();
        end
        else begin
            if (psel && penable && pwrite && pready)
                apply_write(paddr[ADDR_W-1:3], pwdata);
            if (m_tvalid && m_tready)
                check_result(out_t'(m_tdata));
            if (s_tvalid && s_tready) begin
                advance_cycle_stats(in_t'(s_tdata), next_due);
                stats_due.push_back(next_due);
            end
        end
        mismatches  <= mismatch_n;
        outstanding <= stats_due.size();
        compared    <= compared_n;
        overruns    <= over_n;
        sampled     <= samp_n;
    end

endmodule

### test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench of the cycle timing statistics monitor
// Feeds loop timing items into the monitor under a series of register
// settings: a short directed part for the corner cases, then random phases
// of well-formed control loops with occasional overruns and stray wake
// ticks. A checker module beside the block predicts and compares results.
// ----------------------------------------------------------------------------
module testbench;
    import ctsm_pkg::*;

    // No item, with the random gaps around it, comes near WATCHDOG_LIMIT quiet
    // cycles, so a run of that many can only mean a hang.
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int RANDOM_PHASES  = 8;
    localparam int PHASE_ITEMS    = 117;
    // Quiet time at the end, longer than an item with the microsecond conversion takes.
    localparam int SETTLE_CYCLES  = 80;

    logic              clk;
    logic              rst_n;

    logic              s_tvalid;
    logic              s_tready;
    logic [IN_W-1:0]   s_tdata;

    logic              m_tvalid;
    logic              m_tready;
    logic [OUT_W-1:0]  m_tdata;

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    int                mismatches;
    int                outstanding;
    int                compared;
    int                overruns;
    int                sampled;

    // Stimulus side view of the loop: tick_now follows the deadline that the
    // block should be holding, so that starts and wakes land close to it.
    logic [63:0]       tick_now   = '0;
    logic [31:0]       cur_period = PERIOD_RST;
    int unsigned       sent_n     = 0;
    int                settings_n = 1;
    bit                steady_tx  = 1'b0;
    bit                steady_rx  = 1'b0;
    int                quiet      = 0;

    cycle_timing_stats_monitor dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    cycle_stats_checker watch (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .pready      (pready),
        .mismatches  (mismatches),
        .outstanding (outstanding),
        .compared    (compared),
        .overruns    (overruns),
        .sampled     (sampled)
    );

    initial begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // One register write: a setup phase, an access phase held until pready,
    // then an idle phase so that back-to-back writes never drive psel twice
    // in the same time step.
    task automatic reg_write(input logic [2:0] idx, input logic [63:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
        if (idx == REG_PERIOD)
            cur_period = value[31:0];
        if (idx == REG_FDL)
            tick_now = value;
    endtask

    // Offer one item after a random gap and hold it until the block takes it.
    // tvalid stays high on return, so a following item with no gap keeps the
    // stream busy without a low cycle in between.
    task automatic push_sample(input logic [63:0] start, input logic [63:0] wake,
                               input logic [31:0] proc, input logic [15:0] wkc);
        in_t         it;
        int unsigned gap;
        it.start_tick   = start;
        it.wake_tick    = wake;
        it.proc_cycles  = proc;
        it.work_counter = wkc;
        gap = steady_tx ? 0 : $urandom_range(0, 7);
        if (gap != 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= it;
        do @(posedge clk); while (!s_tready);
        sent_n++;
    endtask

    // Stop sending and wait until every result owed has been taken.
    task automatic drain();
        s_tvalid <= 1'b0;
        do @(posedge clk); while (outstanding != 0);
    endtask

    // One loop iteration around the current deadline. Most are on time with
    // a start inside the period and a wake a little before or after the
    // deadline; some start one to three periods late, and a few carry a
    // wake tick from anywhere in the 64-bit range.
    task automatic play_cycle();
        logic [63:0] start;
        logic [63:0] wake;
        logic [31:0] proc;
        logic [15:0] wkc;
        int unsigned pick;
        int unsigned jmax;
        pick = $urandom_range(0, 99);
        jmax = (cur_period > 32'd1) ? ((cur_period > 32'd400) ? 400 : cur_period - 1) : 0;
        wake = tick_now + 64'($urandom_range(0, 300)) - 64'($urandom_range(0, 100));
        if (pick < 8) begin
            tick_now += 64'(cur_period) * $urandom_range(1, 3)
                        + 64'($urandom_range(0, 500));
            start = tick_now;
        end
        else begin
            start = tick_now + 64'($urandom_range(0, jmax));
        end
        if (pick >= 8 && pick < 12)
            wake = {$urandom, $urandom};
        tick_now += 64'(cur_period);
        case ($urandom_range(0, 9))
            0:       proc = 32'd0;
            1:       proc = '1;
            2, 3:    proc = $urandom;
            default: proc = $urandom_range(2000, 9000);
        endcase
        wkc = ($urandom_range(0, 4) == 0) ? 16'd0 : 16'($urandom_range(1, 65535));
        push_sample(start, wake, proc, wkc);
    endtask

    // A fresh setting of every register for one random phase.
    task automatic pick_settings();
        logic [31:0] l0;
        logic [31:0] l1;
        logic [31:0] l2;
        case ($urandom_range(0, 5))
            0:       reg_write(REG_PERIOD, 64'($urandom_range(50, 2000)));
            1:       reg_write(REG_PERIOD, 64'd1);
            2:       reg_write(REG_PERIOD, 64'd0);
            3:       reg_write(REG_PERIOD, 64'hFFFF_FFFF);
            default: reg_write(REG_PERIOD, 64'($urandom_range(500, 100000)));
        endcase
        case ($urandom_range(0, 5))
            0:       reg_write(REG_HZ, 64'd0);
            1:       reg_write(REG_HZ, 64'd1_000_000);
            2:       reg_write(REG_HZ, 64'hFFFF_FFFF);
            3:       reg_write(REG_HZ, 64'd1);
            4:       reg_write(REG_HZ, 64'($urandom_range(100_000, 50_000_000)));
            default: reg_write(REG_HZ, 64'd10_000_000);
        endcase
        // Every accepted item counts as a cycle, so sent_n tells where the
        // block's cycle counter stands.
        case ($urandom_range(0, 2))
            0:       reg_write(REG_WARMUP, 64'd0);
            1:       reg_write(REG_WARMUP, 64'(sent_n + $urandom_range(1, 40)));
            default: reg_write(REG_WARMUP, 64'($urandom_range(0, sent_n)));
        endcase
        case ($urandom_range(0, 2))
            0:       reg_write(REG_FDL, {$urandom, $urandom});
            1:       reg_write(REG_FDL, 64'hFFFF_FFFF_FFFF_FFFF
                                        - 64'($urandom_range(0, 200000)));
            default: reg_write(REG_FDL, 64'($urandom_range(0, 1000)));
        endcase
        if ($urandom_range(0, 5) == 0) begin
            l0 = $urandom;
            l1 = $urandom;
            l2 = $urandom;
        end
        else begin
            l0 = $urandom_range(0, 60);
            l1 = l0 + $urandom_range(0, 150);
            l2 = l1 + $urandom_range(0, 400);
        end
        reg_write(REG_BLIM0, 64'(l0));
        reg_write(REG_BLIM1, 64'(l1));
        reg_write(REG_BLIM2, 64'(l2));
        steady_tx = ($urandom_range(0, 3) == 0);
        steady_rx = ($urandom_range(0, 3) == 0);
    endtask

    // Result side: before each result, stall for a random number of cycles
    // (none at all in steady phases), then stay ready until one is taken.
    initial begin
        int unsigned hold;
        m_tready <= 1'b0;
        while (rst_n !== 1'b1) @(posedge clk);
        forever begin
            hold = steady_rx ? 0 : $urandom_range(0, 7);
            if (hold != 0) begin
                m_tready <= 1'b0;
                repeat (hold) @(posedge clk);
            end
            m_tready <= 1'b1;
            do @(posedge clk); while (m_tvalid !== 1'b1);
        end
    end

    // Watchdog: any handshake on either stream or the register port counts
    // as progress.
    always @(posedge clk) begin
        if (rst_n !== 1'b1 || (s_tvalid && s_tready) || (m_tvalid && m_tready)
            || (psel && penable))
            quiet <= 0;
        else if (quiet >= WATCHDOG_LIMIT) begin
            $display("Watchdog: no progress for %0d cycles", WATCHDOG_LIMIT);
            $display("testbench NOT OK");
            $finish;
        end
        else
            quiet <= quiet + 1;
    end

    initial begin
        rst_n    <= 1'b0;
        s_tvalid <= 1'b0;
        s_tdata  <= '0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: a long warm-up keeps every cycle out of the
        // statistics. The second item starts exactly at deadline plus period,
        // the smallest late start, and the third one wraps the deadline.
        push_sample(64'd0, 64'd0, 32'd0, 16'd0);
        push_sample(64'd2000, 64'd1500, '1, 16'hFFFF);
        push_sample('1, '1, 32'd5, 16'd1);
        drain();

        // Deadline plus period beyond 64 bits: even the largest start is on
        // time. A one-hertz timer makes every nonzero offset huge, and the
        // late start that follows saturates the microsecond value. The first
        // sample after warm-up also sets the minimum.
        reg_write(REG_WARMUP, 64'd3);
        reg_write(REG_HZ, 64'd1);
        reg_write(REG_PERIOD, 64'hFFFF_FFFF);
        reg_write(REG_FDL, 64'hFFFF_FFFF_FFFF_FFF6);
        settings_n++;
        push_sample('1, '1, 32'd7000, 16'h8000);
        push_sample(64'd0, 64'd0, 32'hFFFF_FFFE, 16'd0);
        push_sample('1, 64'h5555_5555_5555_5555, 32'd1, 16'h7FFF);
        push_sample(64'd1, 64'd2, 32'd0, 16'd3);
        drain();

        // Zero period with the deadline at the top of the range: any start at
        // or past it is late. All bucket bounds at zero send everything to the
        // last bucket.
        reg_write(REG_PERIOD, 64'd0);
        reg_write(REG_HZ, 64'hFFFF_FFFF);
        reg_write(REG_FDL, '1);
        reg_write(REG_BLIM0, 64'd0);
        reg_write(REG_BLIM1, 64'd0);
        reg_write(REG_BLIM2, 64'd0);
        settings_n++;
        push_sample('1, 64'd0, 32'h1234_5678, 16'hFFFF);
        push_sample(64'd0, '1, 32'h8765_4321, 16'h00FF);
        push_sample(64'hFFFF_FFFF_FFFF_FFF0, 64'hAAAA_AAAA_AAAA_AAAA,
                    32'hAAAA_AAAA, 16'hAAAA);
        drain();

        // Widest bucket bounds: only an all-ones value, such as a saturated one, misses the first bucket.
        reg_write(REG_BLIM0, 64'hFFFF_FFFF);
        reg_write(REG_BLIM1, 64'hFFFF_FFFF);
        reg_write(REG_BLIM2, 64'hFFFF_FFFF);
        reg_write(REG_HZ, 64'd1_000_000);
        reg_write(REG_PERIOD, 64'(PERIOD_RST));
        reg_write(REG_FDL, 64'd0);
        reg_write(REG_WARMUP, 64'd0);
        settings_n++;
        push_sample(64'd500, 64'd600, 32'h5555_5555, 16'h5555);
        push_sample('1, 64'd0, 32'd3000, 16'd2);
        drain();

        // The longest warm-up: statistics freeze but the counters move on.
        reg_write(REG_WARMUP, 64'hFFFF_FFFF);
        settings_n++;
        push_sample(64'd999, 64'd1200, 32'd4000, 16'd9);
        push_sample(64'd5000, 64'd0, 32'd10, 16'd0);
        drain();

        // Random phases. Register writes only happen once the block is idle;
        // halfway through some phases the sender also waits for every result.
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            drain();
            pick_settings();
            settings_n++;
            for (int k = 0; k < PHASE_ITEMS; k++) begin
                if (k == PHASE_ITEMS / 2 && $urandom_range(0, 1) == 1)
                    drain();
                play_cycle();
            end
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);

        $display("Sent %0d loop items under %0d register settings; %0d results compared.",
                 sent_n, settings_n, compared);
        $display("The block saw %0d overruns and %0d cycles past warm-up.",
                 overruns, sampled);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

### cycle_timing_stats_monitor.f
+incdir+src
src/ctsm_pkg.sv
src/ctsm_alu.sv
src/cycle_timing_stats_monitor.sv
test/cycle_stats_checker.sv
test/testbench.sv
